/* src/tqcp_pkg.sv */
// ----------------------------------------------------------------------------
// tqcp_pkg
// Shared types and codes of the two-queue refcounted cache policy block.
// ----------------------------------------------------------------------------
package tqcp_pkg;

  localparam int CFG_W = 32;

  // register indexes
  localparam logic [1:0] REG_VOLATILE_BUDGET   = 2'd0;
  localparam logic [1:0] REG_FIRST_USE_TARGET  = 2'd1;
  localparam logic [1:0] REG_PERSISTENT_BUDGET = 2'd2;
  localparam logic [1:0] REG_PERSISTENT_LIMIT  = 2'd3;

  localparam logic [CFG_W-1:0] RST_VOLATILE_BUDGET   = 32'd16777216;
  localparam logic [CFG_W-1:0] RST_FIRST_USE_TARGET  = 32'd4194304;
  localparam logic [CFG_W-1:0] RST_PERSISTENT_BUDGET = 32'd8388608;
  localparam logic [CFG_W-1:0] RST_PERSISTENT_LIMIT  = 32'd1048576;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  // place as stored in an entry
  localparam logic [1:0] PL_EMPTY = 2'd0;
  localparam logic [1:0] PL_A1    = 2'd1;
  localparam logic [1:0] PL_MAIN  = 2'd2;
  localparam logic [1:0] PL_PERS  = 2'd3;

  // place as reported
  localparam logic [1:0] OUT_FIRST = 2'd0;
  localparam logic [1:0] OUT_MAIN  = 2'd1;
  localparam logic [1:0] OUT_PERS  = 2'd2;
  localparam logic [1:0] OUT_NONE  = 2'd3;

  typedef struct packed {
    logic        op;
    logic [63:0] res_id;
    logic [31:0] size_bytes;
    logic        persistent;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [1:0]  place;
    logic [7:0]  references;
    logic [5:0]  evicted_count;
    logic [31:0] volatile_used;
    logic [31:0] first_use_used;
    logic [31:0] persistent_used;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0] volatile_budget;
    logic [CFG_W-1:0] first_use_target;
    logic [CFG_W-1:0] persistent_budget;
    logic [CFG_W-1:0] persistent_item_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SWEEP,
    FSM_DECIDE,
    FSM_TRIM,
    FSM_VICTIM,
    FSM_CHECK,
    FSM_INSERT,
    FSM_FINISH
  } fsm_e;

  typedef enum logic [1:0] {
    PH_HIT_MAIN,
    PH_T1_FU,
    PH_T1_MAIN,
    PH_T2_FU
  } phase_e;

  typedef enum logic [1:0] {
    SW_FIND,
    SW_OLDEST,
    SW_ADJUST
  } sweep_e;

endpackage

/* src/two_queue_refcounted_cache_policy.sv */
// ----------------------------------------------------------------------------
// two_queue_refcounted_cache_policy
// 2Q cache replacement policy with reference counts over an entry table.
// ----------------------------------------------------------------------------
//   Input channel in_valid_i / in_stall_o / in_item_i carries acquire and
//   release requests; output channel out_valid_o / out_stall_i / out_item_o
//   returns one result item per request. An item moves when valid is high
//   and stall is low. Configuration registers are to be written through
//   cfg_we_i, cfg_idx_i and cfg_wdata_i only while no request is in flight;
//   the block itself does not enforce this. Each request takes one lookup
//   sweep plus its decision steps. A first-use or main-queue hit and an
//   insert add an age sweep. Each eviction costs a victim search and an age
//   sweep; a trim pass that finds no victim costs a victim search alone.
//   The entry memory has a single read port, and one request is worked on
//   at a time.
//   A result lands in an output register, so the next request is taken
//   while it waits; a stalled receiver holds the block back only once a
//   second result is ready.
//   Reset clears occupancy bits and totals at once and loads the default
//   budgets; the block takes requests in the first cycle after reset.
// ----------------------------------------------------------------------------
module two_queue_refcounted_cache_policy #(
  parameter int ENTRIES   = 32,
  parameter int SIZE_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tqcp_pkg::in_t  in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tqcp_pkg::out_t out_item_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [31:0]    cfg_wdata_i
);

  tqcp_pkg::cfg_t cfg_q, cfg_d;
  tqcp_pkg::out_t out_q, res;
  logic           out_valid_q, out_valid_d;
  logic           idle, res_valid, take;

  tqcp_engine #(.ENTRIES(ENTRIES), .SIZE_BITS(SIZE_BITS)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_take_i  (take),
    .res_o       (res)
  );

  assign take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tqcp_pkg::REG_VOLATILE_BUDGET:   cfg_d.volatile_budget       = cfg_wdata_i;
        tqcp_pkg::REG_FIRST_USE_TARGET:  cfg_d.first_use_target      = cfg_wdata_i;
        tqcp_pkg::REG_PERSISTENT_BUDGET: cfg_d.persistent_budget     = cfg_wdata_i;
        tqcp_pkg::REG_PERSISTENT_LIMIT:  cfg_d.persistent_item_limit = cfg_wdata_i;
        default: ;
      endcase
    end
    if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volatile_budget       <= tqcp_pkg::RST_VOLATILE_BUDGET;
      cfg_q.first_use_target      <= tqcp_pkg::RST_FIRST_USE_TARGET;
      cfg_q.persistent_budget     <= tqcp_pkg::RST_PERSISTENT_BUDGET;
      cfg_q.persistent_item_limit <= tqcp_pkg::RST_PERSISTENT_LIMIT;
      out_valid_q                 <= 1'b0;
      out_q                       <= '0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
      if (take) begin
        out_q <= res;
      end
    end
  end

  assign in_stall_o  = !idle;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* src/tqcp_mem.sv */
// ----------------------------------------------------------------------------
// tqcp_mem
// Entry table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tqcp_mem #(
  parameter int DEPTH = 32,
  parameter int DW    = 111,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/tqcp_engine.sv */
// ----------------------------------------------------------------------------
// tqcp_engine
// Sequencer over the entry table: lookup sweep, victim search sweeps,
// queue age update sweeps, byte totals and per-entry occupancy bits.
// ----------------------------------------------------------------------------
module tqcp_engine #(
  parameter int ENTRIES   = 32,
  parameter int SIZE_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tqcp_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  input  tqcp_pkg::in_t  in_item_i,
  output logic           idle_o,
  output logic           res_valid_o,
  input  logic           res_take_i,
  output tqcp_pkg::out_t res_o
);

  localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW  = AW + 1;
  localparam int SZW = (SIZE_BITS < 32) ? SIZE_BITS : 32;

  typedef struct packed {
    logic [63:0]    key;
    logic [SZW-1:0] bytes;
    logic [7:0]     refs;
    logic [1:0]     place;
    logic [AW-1:0]  age;
  } entry_t;

  localparam int DW = $bits(entry_t);
  localparam logic [CW-1:0] LAST = CW'(ENTRIES);

  tqcp_pkg::fsm_e   state_q, state_d, ret_q, ret_d;
  tqcp_pkg::phase_e phase_q, phase_d, adv_phase;
  tqcp_pkg::sweep_e kind_q, kind_d;
  tqcp_pkg::fsm_e   adv_state;

  logic           op_q, op_d, pers_q, pers_d;
  logic [63:0]    id_q, id_d;
  logic [SZW-1:0] size_q, size_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           rd_vld_q, rd_vld_d;
  logic [AW-1:0]  rd_idx_q, rd_idx_d;
  logic           found_q, found_d;
  logic [AW-1:0]  e_q, e_d;
  entry_t         e_word_q, e_word_d;
  logic           best_vld_q, best_vld_d;
  logic [AW-1:0]  best_idx_q, best_idx_d, best_age_q, best_age_d;
  logic [SZW-1:0] best_bytes_q, best_bytes_d;
  logic [AW-1:0]  tgt_q, tgt_d, old_age_q, old_age_d;
  logic           tgt_en_q, tgt_en_d;
  entry_t         tgt_word_q, tgt_word_d;
  logic [1:0]     old_pl_q, old_pl_d, new_pl_q, new_pl_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [31:0]    vol_q, vol_d, fu_q, fu_d, pt_q, pt_d;
  logic [5:0]     evc_q, evc_d;
  logic [1:0]     rs_status_q, rs_status_d, rs_place_q, rs_place_d;
  logic           rs_hit_q, rs_hit_d;
  logic [7:0]     rs_refs_q, rs_refs_d;

  logic           mem_rd_en, mem_wr_en;
  logic [AW-1:0]  mem_wr_addr;
  logic [DW-1:0]  mem_rd_data, mem_wr_data;
  entry_t         rd_e, nw, ins_word, hit_word;

  logic        free_any;
  logic [AW-1:0] free_idx;
  logic [31:0] sz32, allow;
  logic        over, fu_over, main_over, trim_main_ph, trim_cond, pers_ok;
  logic        sweep_done, rd_ok, is_tgt, inc, dec;
  logic [7:0]  refs_inc, refs_dec;
  logic [1:0]  trim_pl;

  tqcp_mem #(.DEPTH(ENTRIES), .DW(DW), .AW(AW)) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (cnt_q[AW-1:0]),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  assign rd_e = entry_t'(mem_rd_data);

  // lowest empty entry
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int j = ENTRIES - 1; j >= 0; j--) begin
      if (!valid_q[j]) begin
        free_any = 1'b1;
        free_idx = AW'(j);
      end
    end
  end

  assign sz32      = 32'(size_q);
  assign allow     = (cfg_i.volatile_budget > cfg_i.first_use_target) ?
                     (cfg_i.volatile_budget - cfg_i.first_use_target) : '0;
  assign over      = ({1'b0, vol_q} + {1'b0, sz32}) > {1'b0, cfg_i.volatile_budget};
  assign fu_over   = fu_q > cfg_i.first_use_target;
  assign main_over = (vol_q - fu_q) > allow;
  assign pers_ok   = pers_q && (sz32 <= cfg_i.persistent_item_limit) &&
                     (({1'b0, pt_q} + {1'b0, sz32}) <= {1'b0, cfg_i.persistent_budget});

  assign trim_main_ph = (phase_q == tqcp_pkg::PH_HIT_MAIN) || (phase_q == tqcp_pkg::PH_T1_MAIN);
  assign trim_pl      = trim_main_ph ? tqcp_pkg::PL_MAIN : tqcp_pkg::PL_A1;
  assign trim_cond    = trim_main_ph ? main_over : fu_over;

  assign sweep_done = (cnt_q == LAST) && !rd_vld_q;
  assign rd_ok      = valid_q[rd_idx_q];
  assign is_tgt     = tgt_en_q && (rd_idx_q == tgt_q);
  assign inc        = (rd_e.place == new_pl_q);
  assign dec        = (rd_e.place == old_pl_q) && (rd_e.age > old_age_q);

  assign refs_inc = (e_word_q.refs == 8'hFF) ? 8'hFF : e_word_q.refs + 8'd1;
  assign refs_dec = (e_word_q.refs == 8'h00) ? 8'h00 : e_word_q.refs - 8'd1;

  // where a finished trim loop goes
  always_comb begin
    adv_phase = phase_q;
    unique case (phase_q)
      tqcp_pkg::PH_HIT_MAIN: adv_state = tqcp_pkg::FSM_FINISH;
      tqcp_pkg::PH_T1_FU: begin
        adv_state = tqcp_pkg::FSM_TRIM;
        adv_phase = tqcp_pkg::PH_T1_MAIN;
      end
      tqcp_pkg::PH_T1_MAIN:  adv_state = tqcp_pkg::FSM_CHECK;
      tqcp_pkg::PH_T2_FU:    adv_state = tqcp_pkg::FSM_INSERT;
      default:               adv_state = tqcp_pkg::FSM_FINISH;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tqcp_pkg::FSM_IDLE:   if (in_valid_i) state_d = tqcp_pkg::FSM_SWEEP;
      tqcp_pkg::FSM_SWEEP:  if (sweep_done) state_d = ret_q;
      tqcp_pkg::FSM_DECIDE: begin
        if (op_q == tqcp_pkg::OP_RELEASE) begin
          state_d = tqcp_pkg::FSM_FINISH;
        end else if (found_q) begin
          if (e_word_q.place == tqcp_pkg::PL_A1 || e_word_q.place == tqcp_pkg::PL_MAIN) begin
            state_d = tqcp_pkg::FSM_SWEEP;
          end else begin
            state_d = tqcp_pkg::FSM_FINISH;
          end
        end else if (pers_ok) begin
          state_d = tqcp_pkg::FSM_FINISH;
        end else begin
          state_d = tqcp_pkg::FSM_TRIM;
        end
      end
      tqcp_pkg::FSM_TRIM:   state_d = trim_cond ? tqcp_pkg::FSM_SWEEP : adv_state;
      tqcp_pkg::FSM_VICTIM: state_d = best_vld_q ? tqcp_pkg::FSM_SWEEP : adv_state;
      tqcp_pkg::FSM_CHECK:  state_d = over ? tqcp_pkg::FSM_FINISH : tqcp_pkg::FSM_TRIM;
      tqcp_pkg::FSM_INSERT: state_d = free_any ? tqcp_pkg::FSM_SWEEP : tqcp_pkg::FSM_FINISH;
      tqcp_pkg::FSM_FINISH: if (res_take_i) state_d = tqcp_pkg::FSM_IDLE;
      default:              state_d = tqcp_pkg::FSM_IDLE;
    endcase
  end

  // datapath and memory access
  always_comb begin
    ret_d = ret_q;  phase_d = phase_q;  kind_d = kind_q;
    op_d = op_q;  pers_d = pers_q;  id_d = id_q;  size_d = size_q;
    cnt_d = cnt_q;  rd_vld_d = 1'b0;  rd_idx_d = rd_idx_q;
    found_d = found_q;  e_d = e_q;  e_word_d = e_word_q;
    best_vld_d = best_vld_q;  best_idx_d = best_idx_q;
    best_age_d = best_age_q;  best_bytes_d = best_bytes_q;
    tgt_d = tgt_q;  tgt_en_d = tgt_en_q;  tgt_word_d = tgt_word_q;
    old_pl_d = old_pl_q;  old_age_d = old_age_q;  new_pl_d = new_pl_q;
    valid_d = valid_q;  vol_d = vol_q;  fu_d = fu_q;  pt_d = pt_q;  evc_d = evc_q;
    rs_status_d = rs_status_q;  rs_hit_d = rs_hit_q;
    rs_place_d = rs_place_q;  rs_refs_d = rs_refs_q;
    mem_rd_en = 1'b0;  mem_wr_en = 1'b0;  mem_wr_addr = '0;  mem_wr_data = '0;

    ins_word       = '0;
    ins_word.key   = id_q;
    ins_word.bytes = size_q;
    ins_word.refs  = 8'd1;
    hit_word       = e_word_q;
    hit_word.refs  = refs_inc;
    hit_word.place = tqcp_pkg::PL_MAIN;
    hit_word.age   = '0;
    nw             = rd_e;
    nw.age         = rd_e.age + AW'(inc) - AW'(dec);

    unique case (state_q)
      tqcp_pkg::FSM_IDLE: begin
        if (in_valid_i) begin
          op_d        = in_item_i.op;
          id_d        = in_item_i.res_id;
          size_d      = in_item_i.size_bytes[SZW-1:0];
          pers_d      = in_item_i.persistent;
          evc_d       = '0;
          found_d     = 1'b0;
          kind_d      = tqcp_pkg::SW_FIND;
          ret_d       = tqcp_pkg::FSM_DECIDE;
          cnt_d       = '0;
          rs_status_d = tqcp_pkg::STATUS_OK;
          rs_hit_d    = 1'b0;
          rs_place_d  = tqcp_pkg::OUT_NONE;
          rs_refs_d   = '0;
        end
      end
      tqcp_pkg::FSM_SWEEP: begin
        if (cnt_q != LAST) begin
          mem_rd_en = 1'b1;
          cnt_d     = cnt_q + CW'(1);
          rd_vld_d  = 1'b1;
          rd_idx_d  = cnt_q[AW-1:0];
        end
        if (rd_vld_q) begin
          unique case (kind_q)
            tqcp_pkg::SW_FIND: begin
              if (rd_ok && rd_e.key == id_q) begin
                found_d  = 1'b1;
                e_d      = rd_idx_q;
                e_word_d = rd_e;
              end
            end
            tqcp_pkg::SW_OLDEST: begin
              if (rd_ok && rd_e.place == old_pl_q && rd_e.refs == 8'd0 &&
                  (!best_vld_q || rd_e.age > best_age_q)) begin
                best_vld_d   = 1'b1;
                best_idx_d   = rd_idx_q;
                best_age_d   = rd_e.age;
                best_bytes_d = rd_e.bytes;
              end
            end
            tqcp_pkg::SW_ADJUST: begin
              mem_wr_addr = rd_idx_q;
              if (is_tgt) begin
                mem_wr_en   = 1'b1;
                mem_wr_data = tgt_word_q;
              end else if (rd_ok) begin
                mem_wr_en   = 1'b1;
                mem_wr_data = nw;
              end
            end
            default: ;
          endcase
        end
      end
      tqcp_pkg::FSM_DECIDE: begin
        cnt_d = '0;
        if (op_q == tqcp_pkg::OP_RELEASE) begin
          if (found_q) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = e_q;
            nw          = e_word_q;
            nw.refs     = refs_dec;
            mem_wr_data = nw;
            rs_hit_d    = 1'b1;
            rs_place_d  = e_word_q.place - 2'd1;
            rs_refs_d   = refs_dec;
          end
        end else if (found_q) begin
          rs_hit_d  = 1'b1;
          rs_refs_d = refs_inc;
          if (e_word_q.place == tqcp_pkg::PL_PERS) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = e_q;
            mem_wr_data = hit_word;
            nw          = e_word_q;
            nw.refs     = refs_inc;
            mem_wr_data = nw;
            rs_place_d  = tqcp_pkg::OUT_PERS;
          end else begin
            // move to main head: one age sweep does the remove and the push
            if (e_word_q.place == tqcp_pkg::PL_A1) begin
              fu_d  = fu_q - 32'(e_word_q.bytes);
              ret_d = tqcp_pkg::FSM_TRIM;
            end else begin
              ret_d = tqcp_pkg::FSM_FINISH;
            end
            phase_d    = tqcp_pkg::PH_HIT_MAIN;
            kind_d     = tqcp_pkg::SW_ADJUST;
            tgt_d      = e_q;
            tgt_en_d   = 1'b1;
            tgt_word_d = hit_word;
            old_pl_d   = e_word_q.place;
            old_age_d  = e_word_q.age;
            new_pl_d   = tqcp_pkg::PL_MAIN;
            rs_place_d = tqcp_pkg::OUT_MAIN;
          end
        end else if (pers_ok) begin
          if (free_any) begin
            ins_word.place    = tqcp_pkg::PL_PERS;
            mem_wr_en         = 1'b1;
            mem_wr_addr       = free_idx;
            mem_wr_data       = ins_word;
            valid_d[free_idx] = 1'b1;
            pt_d              = pt_q + sz32;
            rs_place_d        = tqcp_pkg::OUT_PERS;
            rs_refs_d         = 8'd1;
          end else begin
            rs_status_d = tqcp_pkg::STATUS_FULL;
          end
        end else begin
          phase_d = over ? tqcp_pkg::PH_T1_FU : tqcp_pkg::PH_T2_FU;
        end
      end
      tqcp_pkg::FSM_TRIM: begin
        cnt_d = '0;
        if (trim_cond) begin
          kind_d     = tqcp_pkg::SW_OLDEST;
          ret_d      = tqcp_pkg::FSM_VICTIM;
          old_pl_d   = trim_pl;
          best_vld_d = 1'b0;
        end else begin
          phase_d = adv_phase;
        end
      end
      tqcp_pkg::FSM_VICTIM: begin
        cnt_d = '0;
        if (best_vld_q) begin
          valid_d[best_idx_q] = 1'b0;
          vol_d = vol_q - 32'(best_bytes_q);
          if (!trim_main_ph) begin
            fu_d = fu_q - 32'(best_bytes_q);
          end
          evc_d     = evc_q + 6'd1;
          kind_d    = tqcp_pkg::SW_ADJUST;
          ret_d     = tqcp_pkg::FSM_TRIM;
          tgt_en_d  = 1'b0;
          old_pl_d  = trim_pl;
          old_age_d = best_age_q;
          new_pl_d  = tqcp_pkg::PL_EMPTY;
        end else begin
          phase_d = adv_phase;
        end
      end
      tqcp_pkg::FSM_CHECK: begin
        if (over) begin
          rs_status_d = tqcp_pkg::STATUS_NO_SPACE;
        end else begin
          phase_d = tqcp_pkg::PH_T2_FU;
        end
      end
      tqcp_pkg::FSM_INSERT: begin
        cnt_d = '0;
        if (free_any) begin
          ins_word.place    = tqcp_pkg::PL_A1;
          valid_d[free_idx] = 1'b1;
          fu_d       = fu_q + sz32;
          vol_d      = vol_q + sz32;
          kind_d     = tqcp_pkg::SW_ADJUST;
          ret_d      = tqcp_pkg::FSM_FINISH;
          tgt_d      = free_idx;
          tgt_en_d   = 1'b1;
          tgt_word_d = ins_word;
          old_pl_d   = tqcp_pkg::PL_EMPTY;
          old_age_d  = '0;
          new_pl_d   = tqcp_pkg::PL_A1;
          rs_place_d = tqcp_pkg::OUT_FIRST;
          rs_refs_d  = 8'd1;
        end else begin
          rs_status_d = tqcp_pkg::STATUS_FULL;
        end
      end
      tqcp_pkg::FSM_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tqcp_pkg::FSM_IDLE;  ret_q <= tqcp_pkg::FSM_IDLE;
      phase_q <= tqcp_pkg::PH_T2_FU;  kind_q <= tqcp_pkg::SW_FIND;
      op_q <= 1'b0;  pers_q <= 1'b0;  id_q <= '0;  size_q <= '0;
      cnt_q <= '0;  rd_vld_q <= 1'b0;  rd_idx_q <= '0;
      found_q <= 1'b0;  e_q <= '0;  e_word_q <= '0;
      best_vld_q <= 1'b0;  best_idx_q <= '0;  best_age_q <= '0;  best_bytes_q <= '0;
      tgt_q <= '0;  tgt_en_q <= 1'b0;  tgt_word_q <= '0;
      old_pl_q <= '0;  old_age_q <= '0;  new_pl_q <= '0;
      valid_q <= '0;  vol_q <= '0;  fu_q <= '0;  pt_q <= '0;  evc_q <= '0;
      rs_status_q <= '0;  rs_hit_q <= 1'b0;  rs_place_q <= '0;  rs_refs_q <= '0;
    end else begin
      state_q <= state_d;  ret_q <= ret_d;  phase_q <= phase_d;  kind_q <= kind_d;
      op_q <= op_d;  pers_q <= pers_d;  id_q <= id_d;  size_q <= size_d;
      cnt_q <= cnt_d;  rd_vld_q <= rd_vld_d;  rd_idx_q <= rd_idx_d;
      found_q <= found_d;  e_q <= e_d;  e_word_q <= e_word_d;
      best_vld_q <= best_vld_d;  best_idx_q <= best_idx_d;
      best_age_q <= best_age_d;  best_bytes_q <= best_bytes_d;
      tgt_q <= tgt_d;  tgt_en_q <= tgt_en_d;  tgt_word_q <= tgt_word_d;
      old_pl_q <= old_pl_d;  old_age_q <= old_age_d;  new_pl_q <= new_pl_d;
      valid_q <= valid_d;  vol_q <= vol_d;  fu_q <= fu_d;  pt_q <= pt_d;  evc_q <= evc_d;
      rs_status_q <= rs_status_d;  rs_hit_q <= rs_hit_d;
      rs_place_q <= rs_place_d;  rs_refs_q <= rs_refs_d;
    end
  end

  assign idle_o      = (state_q == tqcp_pkg::FSM_IDLE);
  assign res_valid_o = (state_q == tqcp_pkg::FSM_FINISH);

  always_comb begin
    res_o                 = '0;
    res_o.status          = rs_status_q;
    res_o.hit             = rs_hit_q;
    res_o.place           = rs_place_q;
    res_o.references      = rs_refs_q;
    res_o.evicted_count   = evc_q;
    res_o.volatile_used   = vol_q;
    res_o.first_use_used  = fu_q;
    res_o.persistent_used = pt_q;
  end

endmodule

/* src/tqcp_checker.sv */
// ----------------------------------------------------------------------------
// tqcp_checker
// Port-level checks of the cache policy block, bound to the top level.
// ----------------------------------------------------------------------------
module tqcp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input tqcp_pkg::out_t out_item_o
);

  // a taken request keeps the engine busy for at least its lookup sweep
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while engine busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result dropped or changed");

  a_fail_no_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != tqcp_pkg::STATUS_OK |->
      out_item_o.place == tqcp_pkg::OUT_NONE && !out_item_o.hit)
    else $error("failed request reports a placement");

  a_none_no_refs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.place == tqcp_pkg::OUT_NONE |->
      out_item_o.references == 8'd0)
    else $error("reference count without an entry");

  a_fu_within_vol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.first_use_used <= out_item_o.volatile_used)
    else $error("first-use bytes exceed volatile bytes");

endmodule

bind two_queue_refcounted_cache_policy tqcp_checker u_tqcp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
